>>> src/tsrqs_pkg.sv
// Package for the tick-stamped replay queue select unit.
// Holds queue sizing constants, command/mode/outcome codes and payload types.
// No dependencies.
`timescale 1ns / 1ps

package tsrqs_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STAMP_W     = 33;
  localparam int unsigned TICK_W      = 32;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_SELECT   = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_BLOCKING = 2'd1,
    MODE_NONBLOCK = 2'd2,
    MODE_INVALID  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OUT_INVALID   = 4'd0,
    OUT_OUTSIDE   = 4'd1,
    OUT_VERSION   = 4'd2,
    OUT_INACTIVE  = 4'd3,
    OUT_NOPACKET  = 4'd4,
    OUT_EXACT     = 4'd5,
    OUT_STALE     = 4'd6,
    OUT_FUTURE    = 4'd7,
    OUT_CANCELLED = 4'd8,
    OUT_EMPTY     = 4'd9,
    OUT_LOADED    = 4'd10,
    OUT_FULL      = 4'd11
  } outcome_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [STAMP_W-1:0] pkt_stamp;
    logic [TICK_W-1:0]  query_tick;
    logic               in_race;
    logic               version_match;
    logic               block_still_active;
  } in_item_t;

  typedef struct packed {
    logic [3:0] outcome;
    logic [8:0] head_next;
    logic [7:0] sel_index;
    logic [8:0] stale_count;
    logic       has_selected;
  } out_item_t;

  // Reported positions are masked to the field widths of the result.
  function automatic logic [8:0] fit9(input logic [CNT_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[8:0];
  endfunction

  function automatic logic [7:0] fit8(input logic [CNT_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[7:0];
  endfunction

endpackage

>>> src/tsrqs_if.sv
// Valid/ready channel interfaces for the replay queue select unit.
// Depends on tsrqs_pkg for the payload types.
`timescale 1ns / 1ps

interface tsrqs_in_if;
  logic                valid;
  logic                ready;
  tsrqs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsrqs_out_if;
  logic                 valid;
  logic                 ready;
  tsrqs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/tsrqs_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tsrqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/tick_stamped_replay_queue_select_unit.sv
// Top level of the tick-stamped replay queue select unit.
// Append, clear and early-out selections give their result in the cycle after the
// transaction (one transaction per cycle while idle and the output is free); a selection
// that reads the queue examines entries at one RAM read per cycle, the stale ones walked
// plus the entry that stops the walk. Reset clears mode, fill count, head and handshake
// state; the stamp RAM is not cleared. Depends on tsrqs_pkg, tsrqs_if and tsrqs_ram.
`timescale 1ns / 1ps

module tick_stamped_replay_queue_select_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  tsrqs_in_if.sink          in_i,
  tsrqs_out_if.source       out_o
);

  localparam int unsigned CNT_W  = tsrqs_pkg::CNT_W;
  localparam int unsigned ADDR_W = tsrqs_pkg::ADDR_W;

  // Control state.
  tsrqs_pkg::state_e    state_q, state_d;
  logic [1:0]           mode_q;
  logic [CNT_W-1:0]     loaded_q, loaded_d;
  logic [CNT_W-1:0]     head_q, head_d;

  // Walk context: the entry being examined, stale entries passed so far and the tick
  // of the query. The non-blocking flag limits the walk to the head entry.
  logic [CNT_W-1:0]     cur_q, cur_d;
  logic [CNT_W-1:0]     stale_q, stale_d;
  logic [31:0]          now_q, now_d;
  logic                 nonblk_q, nonblk_d;

  // Output register; it frees itself in the cycle the result is taken.
  logic                 out_valid_q, out_valid_d;
  tsrqs_pkg::out_item_t out_data_q, out_data_d;

  // Stamp RAM ports.
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [32:0]          ram_rdata;

  logic                 in_ready;
  logic                 in_take;
  logic                 res_load;
  tsrqs_pkg::out_item_t res;
  logic [CNT_W-1:0]     nxt;
  logic [CNT_W-1:0]     stale_inc;

  tsrqs_ram #(
    .WIDTH (tsrqs_pkg::STAMP_W),
    .DEPTH (tsrqs_pkg::QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data.pkt_stamp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A new transaction is taken only between selections, and only when the output
  // register is empty or being drained, so any result fits without a stall.
  assign in_ready    = (state_q == tsrqs_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_take     = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign ram_waddr = loaded_q[ADDR_W-1:0];
  assign nxt       = cur_q + CNT_W'(1);
  assign stale_inc = stale_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    head_d      = head_q;
    cur_d       = cur_q;
    stale_d     = stale_q;
    now_d       = now_q;
    nonblk_d    = nonblk_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_q[ADDR_W-1:0];
    res_load    = 1'b0;
    res         = '0;
    res.head_next = tsrqs_pkg::fit9(head_q);

    case (state_q)
      tsrqs_pkg::ST_IDLE: begin
        if (in_take) begin
          case (in_i.data.command)
            tsrqs_pkg::CMD_APPEND: begin
              res_load = 1'b1;
              if (loaded_q < CNT_W'(tsrqs_pkg::QUEUE_DEPTH)) begin
                ram_we      = 1'b1;
                loaded_d    = loaded_q + CNT_W'(1);
                res.outcome = tsrqs_pkg::OUT_LOADED;
              end else begin
                res.outcome = tsrqs_pkg::OUT_FULL;
              end
            end
            tsrqs_pkg::CMD_SELECT: begin
              now_d    = in_i.data.query_tick;
              cur_d    = head_q;
              stale_d  = '0;
              nonblk_d = (mode_q == tsrqs_pkg::MODE_NONBLOCK);
              res_load = 1'b1;
              // The condition checks go in a fixed order; the first failure reports.
              if (!in_i.data.in_race) begin
                res.outcome = tsrqs_pkg::OUT_OUTSIDE;
              end else if (!in_i.data.version_match) begin
                res.outcome = tsrqs_pkg::OUT_VERSION;
              end else if (mode_q == tsrqs_pkg::MODE_INACTIVE) begin
                res.outcome = tsrqs_pkg::OUT_INACTIVE;
              end else if (mode_q == tsrqs_pkg::MODE_INVALID) begin
                res.outcome = tsrqs_pkg::OUT_INVALID;
              end else if ((mode_q == tsrqs_pkg::MODE_BLOCKING) &&
                           !in_i.data.block_still_active) begin
                res.outcome = tsrqs_pkg::OUT_CANCELLED;
              end else if (head_q >= loaded_q) begin
                res.outcome = (mode_q == tsrqs_pkg::MODE_NONBLOCK) ?
                              tsrqs_pkg::OUT_NOPACKET : tsrqs_pkg::OUT_EMPTY;
              end else begin
                // Queue holds at least one entry: fetch the head and start the walk.
                res_load = 1'b0;
                ram_re   = 1'b1;
                state_d  = tsrqs_pkg::ST_WALK;
              end
            end
            tsrqs_pkg::CMD_CLEAR: begin
              loaded_d      = '0;
              head_d        = '0;
              res_load      = 1'b1;
              res.outcome   = tsrqs_pkg::OUT_LOADED;
              res.head_next = '0;
            end
            default: begin
              res_load    = 1'b1;
              res.outcome = tsrqs_pkg::OUT_INVALID;
            end
          endcase
        end
      end
      tsrqs_pkg::ST_WALK: begin
        // The stamp of entry cur_q arrived from the RAM this cycle.
        res_load        = 1'b1;
        state_d         = tsrqs_pkg::ST_IDLE;
        res.head_next   = tsrqs_pkg::fit9(cur_q);
        res.stale_count = tsrqs_pkg::fit9(stale_q);
        head_d          = cur_q;
        if (ram_rdata[32]) begin
          // An over-wide stamp stops the walk; the head rests on it.
          res.outcome = tsrqs_pkg::OUT_INVALID;
        end else if (ram_rdata[31:0] == now_q) begin
          res.outcome      = tsrqs_pkg::OUT_EXACT;
          res.head_next    = tsrqs_pkg::fit9(nxt);
          res.sel_index    = tsrqs_pkg::fit8(cur_q);
          res.has_selected = 1'b1;
          head_d           = nxt;
        end else if (ram_rdata[31:0] < now_q) begin
          res.head_next   = tsrqs_pkg::fit9(nxt);
          res.stale_count = tsrqs_pkg::fit9(stale_inc);
          head_d          = nxt;
          if (nonblk_q) begin
            res.outcome = tsrqs_pkg::OUT_STALE;
          end else if (nxt >= loaded_q) begin
            res.outcome = tsrqs_pkg::OUT_EMPTY;
          end else begin
            // Drop this stale entry and fetch the next one.
            res_load  = 1'b0;
            state_d   = tsrqs_pkg::ST_WALK;
            head_d    = head_q;
            cur_d     = nxt;
            stale_d   = stale_inc;
            ram_re    = 1'b1;
            ram_raddr = nxt[ADDR_W-1:0];
          end
        end else begin
          res.outcome = tsrqs_pkg::OUT_FUTURE;
        end
      end
      default: begin
        state_d = tsrqs_pkg::ST_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsrqs_pkg::ST_IDLE;
      mode_q      <= tsrqs_pkg::MODE_INACTIVE;
      loaded_q    <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and walk context need no reset.
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    stale_q    <= stale_d;
    now_q      <= now_d;
    nonblk_q   <= nonblk_d;
    out_data_q <= out_data_d;
  end

  // The head never passes the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= loaded_q)
    else $error("head position beyond fill count");

  // The fill count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CNT_W'(tsrqs_pkg::QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // While a walk runs the output register is empty, so its result never waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsrqs_pkg::ST_WALK) |-> !out_valid_q)
    else $error("output register occupied during walk");

  // A walk that continues examines entries still inside the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsrqs_pkg::ST_WALK) |-> (cur_q < loaded_q))
    else $error("walk entry outside the queue");

  // A walk step that does not finish drops exactly one more stale entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsrqs_pkg::ST_WALK) && (state_d == tsrqs_pkg::ST_WALK)
    |=> (stale_q == $past(stale_q) + CNT_W'(1)))
    else $error("stale count did not advance by one");

endmodule
